// ===== rtl/core/lmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and codes for the LED matrix column shifter.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_REFRESH = 2'd1;
  localparam logic [1:0] FUNC_INIT    = 2'd2;
  localparam logic [1:0] FUNC_LINE    = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CORR = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  localparam logic [5:0] CORR_RESET = 6'd63;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] col_x;
    logic [2:0] row_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_word;
    logic       last;
    logic [7:0] line_mask;
  } out_item_t;

  typedef enum logic [1:0] {
    ISS_DATA = 2'd0,
    ISS_CORR = 2'd1,
    ISS_LINE = 2'd2
  } iss_sel_t;

  typedef struct packed {
    logic     load;
    logic     pix;
    logic     cnt_inc;
    logic     we;
    logic     clr;
    logic     issue;
    iss_sel_t iss_sel;
    logic     set_lines;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_end;
    logic px_end;
    logic col_end;
    logic init_end;
    logic credit_ok;
    logic col_ok;
    logic pix_ok;
  } dp_stat_t;

endpackage

// ===== rtl/core/lmcs_ifs.sv =====
// ----------------------------------------------------------------------------
// lmcs channel interfaces
// Valid/ready channels for input items, results and the correction register.
// ----------------------------------------------------------------------------
interface lmcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] col_x;
  logic [2:0] row_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, col_x, row_y, red, green, blue, input ready);
  modport sink (input valid, func, col_x, row_y, red, green, blue, output ready);
endinterface

interface lmcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_word;
  logic       last;
  logic [7:0] line_mask;

  modport source (output valid, kind, data_word, last, line_mask, input ready);
  modport sink (input valid, kind, data_word, last, line_mask, output ready);
endinterface

interface lmcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] correction_value;

  modport source (output valid, correction_value, input ready);
  modport sink (input valid, correction_value, output ready);
endinterface

// ===== rtl/core/lmcs_ram.sv =====
// ----------------------------------------------------------------------------
// lmcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lmcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmcs_ctrl
// Sequencer: clearing pass, pixel write, column refresh, init and line select.
// ----------------------------------------------------------------------------
module lmcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_ready,
  input  lmcs_pkg::dp_stat_t stat,
  output lmcs_pkg::dp_cmd_t  cmd
);
  import lmcs_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WRITE = 6'b000100,
    S_READ  = 6'b001000,
    S_INIT  = 6'b010000,
    S_LINE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.iss_sel = ISS_DATA;
    case (state_r)
      S_CLEAR: begin
        cmd.we      = 1'b1;
        cmd.clr     = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.clr_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.pix  = (in_func == FUNC_WRITE);
          case (in_func)
            FUNC_WRITE:   state_nxt = stat.pix_ok ? S_WRITE : S_IDLE;
            FUNC_REFRESH: state_nxt = stat.col_ok ? S_READ : S_IDLE;
            FUNC_INIT:    state_nxt = S_INIT;
            FUNC_LINE:    state_nxt = S_LINE;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.we      = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.px_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.iss_sel = ISS_DATA;
        if (stat.credit_ok) begin
          cmd.issue   = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.col_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_INIT: begin
        cmd.iss_sel = ISS_CORR;
        if (stat.credit_ok) begin
          cmd.issue   = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.init_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LINE: begin
        cmd.iss_sel = ISS_LINE;
        if (stat.credit_ok) begin
          cmd.issue     = 1'b1;
          cmd.set_lines = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/lmcs_dp.sv =====
// ----------------------------------------------------------------------------
// lmcs_dp
// Datapath: item registers, counter, frame buffer addressing, issue stage
// and a three-entry result queue.
// ----------------------------------------------------------------------------
module lmcs_dp #(
  parameter int MATRIX_SIZE      = 8,
  parameter int CORRECTION_WORDS = 24,
  parameter int DEPTH            = 192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lmcs_pkg::in_item_t        in_item,
  input  logic                      cfg_we,
  input  logic [5:0]                cfg_data,
  input  lmcs_pkg::dp_cmd_t         cmd,
  output lmcs_pkg::dp_stat_t        stat,
  output logic                      mem_we,
  output logic [$clog2(DEPTH)-1:0]  mem_waddr,
  output logic [7:0]                mem_wdata,
  output logic [$clog2(DEPTH)-1:0]  mem_raddr,
  input  logic [7:0]                mem_rdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lmcs_pkg::out_item_t       out_item
);
  import lmcs_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int STRIDE  = 3 * MATRIX_SIZE;
  localparam int CNT_MAX = (DEPTH > CORRECTION_WORDS) ? DEPTH : CORRECTION_WORDS;
  localparam int CW      = $clog2(CNT_MAX);
  localparam int QD      = 3;

  logic [3:0]    col_r;
  logic [7:0]    red_r, green_r, blue_r;
  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] cnt_r;
  logic [5:0]    corr_r;
  logic [7:0]    lines_r;
  logic [7:0]    mask_new;

  logic       stg_v_r;
  logic       stg_mem_r;
  logic [1:0] stg_kind_r;
  logic [7:0] stg_word_r;
  logic       stg_last_r;
  logic [7:0] stg_mask_r;

  out_item_t  q_r [QD];
  logic [1:0] wptr_r, rptr_r, qcnt_r;
  logic       push, pop;
  out_item_t  push_item;

  always_comb begin
    base_nxt = AW'(32'(in_item.col_x) * STRIDE);
    if (cmd.pix) begin
      base_nxt = base_nxt + AW'(32'(in_item.row_y) * 3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_item.col_x;
      red_r   <= in_item.red;
      green_r <= in_item.green;
      blue_r  <= in_item.blue;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      corr_r  <= CORR_RESET;
      lines_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cfg_we) begin
        corr_r <= cfg_data;
      end
      if (cmd.set_lines) begin
        lines_r <= mask_new;
      end
    end
  end

  assign mask_new = (32'(col_r) < MATRIX_SIZE && !col_r[3]) ? (8'b1 << col_r[2:0]) : 8'h00;

  assign mem_we    = cmd.we;
  assign mem_waddr = cmd.clr ? AW'(cnt_r) : base_r + AW'(cnt_r);
  assign mem_raddr = base_r + AW'(cnt_r);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mem_wdata = blue_r;
      2'd1:    mem_wdata = green_r;
      default: mem_wdata = red_r;
    endcase
    if (cmd.clr) begin
      mem_wdata = 8'h00;
    end
  end

  always_comb begin
    stat.clr_end   = (cnt_r == CW'(DEPTH - 1));
    stat.px_end    = (cnt_r == CW'(2));
    stat.col_end   = (cnt_r == CW'(STRIDE - 1));
    stat.init_end  = (cnt_r == CW'(CORRECTION_WORDS - 1));
    stat.credit_ok = (32'(qcnt_r) + 32'(stg_v_r)) < QD;
    stat.col_ok    = 32'(in_item.col_x) < MATRIX_SIZE;
    stat.pix_ok    = (32'(in_item.col_x) < MATRIX_SIZE) && (32'(in_item.row_y) < MATRIX_SIZE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      case (cmd.iss_sel)
        ISS_DATA: begin
          stg_mem_r  <= 1'b1;
          stg_kind_r <= KIND_DATA;
          stg_word_r <= 8'h00;
          stg_last_r <= stat.col_end;
          stg_mask_r <= lines_r;
        end
        ISS_CORR: begin
          stg_mem_r  <= 1'b0;
          stg_kind_r <= KIND_CORR;
          stg_word_r <= {2'b00, corr_r};
          stg_last_r <= stat.init_end;
          stg_mask_r <= lines_r;
        end
        default: begin
          stg_mem_r  <= 1'b0;
          stg_kind_r <= KIND_LINE;
          stg_word_r <= 8'h00;
          stg_last_r <= 1'b0;
          stg_mask_r <= mask_new;
        end
      endcase
    end
  end

  assign push = stg_v_r;
  assign pop  = out_valid && out_ready;

  always_comb begin
    push_item.kind      = stg_kind_r;
    push_item.data_word = stg_mem_r ? mem_rdata : stg_word_r;
    push_item.last      = stg_last_r;
    push_item.line_mask = stg_mask_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == 2'(QD - 1)) ? 2'd0 : wptr_r + 2'd1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == 2'(QD - 1)) ? 2'd0 : rptr_r + 2'd1;
      end
      qcnt_r <= qcnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_valid = (qcnt_r != 2'd0);
  assign out_item  = q_r[rptr_r];

endmodule

// ===== rtl/core/led_matrix_column_shifter.sv =====
// ----------------------------------------------------------------------------
// led_matrix_column_shifter
// Column refresh: an accept, then 3*MATRIX_SIZE issues with one frame buffer
//   read per cycle while the result queue has credit.
// Init: CORRECTION_WORDS words; line select: one; pixel write: 3 RAM writes.
// Reset: a clearing pass zeroes all 3*MATRIX_SIZE^2 words (192 at default) of
//   the frame buffer; no input transaction is taken meanwhile, cfg writes are.
// ----------------------------------------------------------------------------
module led_matrix_column_shifter #(
  parameter int MATRIX_SIZE      = 8,
  parameter int CORRECTION_WORDS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  lmcs_in_if.sink      in_ch,
  lmcs_out_if.source   out_ch,
  lmcs_cfg_if.sink     cfg_ch
);
  import lmcs_pkg::*;

  localparam int DEPTH = 3 * MATRIX_SIZE * MATRIX_SIZE;
  localparam int AW    = $clog2(DEPTH);

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          in_ready;

  always_comb begin
    in_item.func  = in_ch.func;
    in_item.col_x = in_ch.col_x;
    in_item.row_y = in_ch.row_y;
    in_item.red   = in_ch.red;
    in_item.green = in_ch.green;
    in_item.blue  = in_ch.blue;
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.kind      = out_item.kind;
  assign out_ch.data_word = out_item.data_word;
  assign out_ch.last      = out_item.last;
  assign out_ch.line_mask = out_item.line_mask;

  lmcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmcs_dp #(
    .MATRIX_SIZE      (MATRIX_SIZE),
    .CORRECTION_WORDS (CORRECTION_WORDS),
    .DEPTH            (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.correction_value),
    .cmd       (cmd),
    .stat      (stat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  lmcs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
